// File: rtl/rct_pkg.sv
// Package for the RC capacitance timer: widths, reset values, codes and the
// request, response and inter-stage struct types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rct_pkg;

   // Field widths
   localparam int ADC_BITS   = 12;
   localparam int TICK_BITS  = 32;
   localparam int SCALE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CAP_BITS   = TICK_BITS + SCALE_BITS - FRAC_BITS;
   localparam int PROD_BITS  = TICK_BITS + SCALE_BITS;
   localparam int PHASE_BITS = 3;

   // Configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = SCALE_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HIGH_THR  = 2'd0,
      CSR_LOW_THR   = 2'd1,
      CSR_CAP_SCALE = 2'd2
   } csr_idx_type;

   // Register reset values
   localparam logic [ADC_BITS-1:0]   HIGH_THR_RST  = ADC_BITS'(2482);
   localparam logic [ADC_BITS-1:0]   LOW_THR_RST   = ADC_BITS'(1241);
   localparam logic [SCALE_BITS-1:0] CAP_SCALE_RST = SCALE_BITS'(11439993);

   // Measurement phases
   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE   = 3'd0,
      PH_WAIT   = 3'd1,
      PH_DISCH  = 3'd2,
      PH_CHARGE = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // Request function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_START  = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [ADC_BITS-1:0]  adc_sample;
      logic [TICK_BITS-1:0] tick_ms;
   } req_type;

   typedef struct packed {
      logic                  charge_drive;
      logic [PHASE_BITS-1:0] phase;
      logic                  done_res;
      logic [TICK_BITS-1:0]  elapsed_ms;
      logic [CAP_BITS-1:0]   capacitance_nf;
   } rsp_type;

   typedef struct packed {
      logic [ADC_BITS-1:0]   high_thr;
      logic [ADC_BITS-1:0]   low_thr;
      logic [SCALE_BITS-1:0] cap_scale;
   } cfg_type;

   // State stage to multiply stage
   typedef struct packed {
      logic                  charge_drive;
      logic [PHASE_BITS-1:0] phase;
      logic                  done_res;
      logic [TICK_BITS-1:0]  elapsed_ms;
      logic                  cap_upd;
   } stage_type;

endpackage

// File: rtl/rct_csr.sv
// Configuration registers of the RC capacitance timer (thresholds, scale).
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rct_pkg::CSR_IDX_BITS-1:0]    csr_idx,
   input  logic [rct_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output rct_pkg::cfg_type                    cfg
);
   import rct_pkg::*;

   logic [ADC_BITS-1:0]   high_thr_ff;
   logic [ADC_BITS-1:0]   low_thr_ff;
   logic [SCALE_BITS-1:0] cap_scale_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff  <= HIGH_THR_RST;
         low_thr_ff   <= LOW_THR_RST;
         cap_scale_ff <= CAP_SCALE_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_HIGH_THR:  high_thr_ff  <= csr_wdata[ADC_BITS-1:0];
            CSR_LOW_THR:   low_thr_ff   <= csr_wdata[ADC_BITS-1:0];
            CSR_CAP_SCALE: cap_scale_ff <= csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.high_thr  = high_thr_ff;
   assign cfg.low_thr   = low_thr_ff;
   assign cfg.cap_scale = cap_scale_ff;

endmodule

// File: rtl/rct_fsm.sv
// Input register and measurement state machine of the RC capacitance timer.
// Produces the per-request state snapshot for the multiply stage. Uses rct_pkg.
`timescale 1ns / 1ps

module rct_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rct_pkg::req_type    req_data,
   input  rct_pkg::cfg_type    cfg,
   output logic                st_valid,
   input  logic                st_ready,
   output rct_pkg::stage_type  st_data
);
   import rct_pkg::*;

   // Input register
   logic    in_vld_ff;
   req_type in_ff;

   // Measurement state
   phase_type            phase_ff, phase_in;
   logic [TICK_BITS-1:0] start_tick_ff, start_tick_in;
   logic                 drive_ff, drive_in;
   logic                 done_ff, done_in;
   logic [TICK_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 cap_upd;

   // Stage register toward the multiplier
   logic      st_vld_ff;
   stage_type st_ff;

   logic step;

   // State advances when a request is held and the stage register can take the snapshot
   assign step      = in_vld_ff && (!st_vld_ff || st_ready);
   assign req_ready = !in_vld_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         start_tick_ff <= '0;
         drive_ff      <= 1'b0;
         done_ff       <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         start_tick_ff <= start_tick_in;
         drive_ff      <= drive_in;
         done_ff       <= done_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // Next state: one request per step
   always_comb begin
      phase_in      = phase_ff;
      start_tick_in = start_tick_ff;
      drive_in      = drive_ff;
      done_in       = done_ff;
      elapsed_in    = elapsed_ff;
      cap_upd       = 1'b0;
      if (step) begin
         if (in_ff.func == FUNC_START) begin
            phase_in = PH_WAIT;
            done_in  = 1'b0;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  drive_in = 1'b1;
                  if (in_ff.adc_sample > cfg.high_thr) phase_in = PH_DISCH;
               end
               PH_DISCH: begin
                  drive_in = 1'b0;
                  if (in_ff.adc_sample < cfg.low_thr) begin
                     phase_in      = PH_CHARGE;
                     drive_in      = 1'b1;
                     start_tick_in = in_ff.tick_ms;
                  end
               end
               PH_CHARGE: begin
                  // wrapping difference of the tick counter
                  if (in_ff.adc_sample > cfg.high_thr) begin
                     elapsed_in = in_ff.tick_ms - start_tick_ff;
                     cap_upd    = 1'b1;
                     phase_in   = PH_DONE;
                  end
               end
               PH_DONE: begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // Snapshot of the updated state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
      end else if (!st_vld_ff || st_ready) begin
         st_vld_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         st_ff.charge_drive <= drive_in;
         st_ff.phase        <= phase_in;
         st_ff.done_res     <= done_in;
         st_ff.elapsed_ms   <= elapsed_in;
         st_ff.cap_upd      <= cap_upd;
      end
   end

   assign st_valid = st_vld_ff;
   assign st_data  = st_ff;

endmodule

// File: rtl/rct_mult.sv
// Capacitance stage of the RC capacitance timer: elapsed times scale in Q16.16,
// the held capacitance value and the response register. Uses rct_pkg.
`timescale 1ns / 1ps

module rct_mult (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                st_valid,
   output logic                                st_ready,
   input  rct_pkg::stage_type                  st_data,
   input  logic [rct_pkg::SCALE_BITS-1:0]      cap_scale,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rct_pkg::rsp_type                    rsp_data
);
   import rct_pkg::*;

   logic                 rsp_vld_ff;
   rsp_type              rsp_ff;
   logic [CAP_BITS-1:0]  cap_ff, cap_in;
   logic [PROD_BITS-1:0] product;
   logic                 move;

   assign st_ready = !rsp_vld_ff || rsp_ready;
   assign move     = st_valid && st_ready;

   // 32 x 32 product, drop the fraction bits
   assign product = PROD_BITS'(st_data.elapsed_ms) * PROD_BITS'(cap_scale);
   assign cap_in  = (move && st_data.cap_upd) ? product[PROD_BITS-1:FRAC_BITS] : cap_ff;

   // Last measured capacitance
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (st_ready) begin
         rsp_vld_ff <= st_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff.charge_drive   <= st_data.charge_drive;
         rsp_ff.phase          <= st_data.phase;
         rsp_ff.done_res       <= st_data.done_res;
         rsp_ff.elapsed_ms     <= st_data.elapsed_ms;
         rsp_ff.capacitance_nf <= cap_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/rc_capacitance_timer_core.sv
// Top level of the RC capacitance timer: configuration registers, state
// machine stage and capacitance stage. Depends on rct_pkg, rct_csr, rct_fsm, rct_mult.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): func = start begins a measurement,
//   func = sample delivers one ADC code with its millisecond tick.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one response per request,
//   in order: pin level, phase, sticky done flag, last elapsed time and last
//   capacitance in nF (elapsed * cap_scale >> 16).
//   csr port: csr_we writes csr_wdata to register csr_idx (0 high threshold,
//   1 low threshold, 2 scale); write only while no request is in flight.
// Path: the input register loads at the accepting edge, then the state stage
//   register, then the response register drives rsp_valid. Throughput: one
//   request per cycle while rsp_ready does not stall, set by the state update
//   and the one 32x32 multiplier in the last stage.
// Reset (synchronous, high): pipeline empty, phase idle, pin low, results zero,
//   registers at their default values.
// Stall: an rsp_ready held low backs up stage by stage; the two inner registers
//   still fill, so up to three requests are taken before req_ready drops.
`timescale 1ns / 1ps

module rc_capacitance_timer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rct_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rct_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [rct_pkg::CSR_IDX_BITS-1:0]   csr_idx,
   input  logic [rct_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rct_pkg::*;

   cfg_type   cfg;
   logic      st_valid;
   logic      st_ready;
   stage_type st_data;

   rct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rct_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .st_valid  (st_valid),
      .st_ready  (st_ready),
      .st_data   (st_data)
   );

   rct_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .st_valid  (st_valid),
      .st_ready  (st_ready),
      .st_data   (st_data),
      .cap_scale (cfg.cap_scale),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/rct_checker.sv
// Port-level assertions for the RC capacitance timer and their bind to the
// top level. Depends on rct_pkg and rc_capacitance_timer_core.
`timescale 1ns / 1ps

module rct_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  rct_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  rct_pkg::rsp_type                   rsp_data
);
   import rct_pkg::*;

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset empties the pipeline
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A waiting request holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   // Charging and done drive the pin high
   a_charge_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.phase == PH_CHARGE || rsp_data.phase == PH_DONE)
      |-> rsp_data.charge_drive)
      else $error("pin low while charging");

   // Done flag only shows once the measurement is back to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.phase == PH_IDLE)
      else $error("done flag set during a measurement");

endmodule

bind rc_capacitance_timer_core rct_checker u_rct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
